// ===== rtl/core/lzoc_pkg.sv =====
// Shared types, constants and sine table generator for the lidar zone obstacle classifier.
`default_nettype none

package lzoc_pkg;

  // Configuration port geometry
  localparam int unsigned CFG_IDX_W  = 5;
  localparam int unsigned CFG_DATA_W = 64;

  // Register reset values: window min 0 / max 1500, mount x 342 / y 215 / angle quarter turn
  localparam logic [31:0] RANGE_WINDOW_RST = 32'h05DC_0000;
  localparam logic [47:0] MOUNT_POSE_RST   = 48'h4000_00D7_0156;

  // Hit counters
  localparam int unsigned CNT_W   = 12;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // Robot-frame coordinate width: 16-bit offset plus 18-bit rotated range
  localparam int unsigned COORD_W = 19;

  // Binary angle of a quarter turn, turns sine into cosine
  localparam logic [15:0] QUARTER_TURN = 16'h4000;

  // pi/2 in Q30 and the Taylor series divisors (n+1)(n+2) for odd n
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned TAYLOR_DIV [11] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
    64'd210, 64'd272, 64'd342, 64'd420, 64'd506
  };

  // Input transfer payload
  typedef struct packed {
    logic        [15:0] range_mm;
    logic signed [15:0] beam_angle;
    logic        [1:0]  area_disable;
    logic               last_point;
  } in_t;

  // Output transfer payload
  typedef struct packed {
    logic [1:0] front_level;
    logic [1:0] side_level;
  } out_t;

  // Transformed point handed to the zone stage
  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic                      keep;
    logic [1:0]                area_disable;
    logic                      last_point;
  } pt_t;

  // Sign-extend a 16-bit millimetre value to coordinate width
  function automatic logic signed [COORD_W-1:0] sext_mm(logic [15:0] v);
    return {{(COORD_W-16){v[15]}}, v};
  endfunction

  // Quarter-wave sine entry k in 1.15, evaluated at elaboration only
  function automatic logic [15:0] sine_entry(int unsigned k, int unsigned bits);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned r;
    longint          sum;
    bit              neg;
    x    = (HALF_PI_Q30 * longint'(k)) >> (bits - 2);
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    neg  = 1'b1;
    for (int i = 0; i < 11; i++) begin
      term = ((term * x2) >> 30) / TAYLOR_DIV[i];
      if (neg) sum = sum - longint'(term);
      else     sum = sum + longint'(term);
      neg = !neg;
    end
    if (sum < 0) sum = 0;
    r = (longint'(sum) + 64'd16384) >> 15;
    if (r > 64'd32767) r = 64'd32767;
    return r[15:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/lzoc_sine.sv =====
// Quarter-wave sine table lookup with quadrant folding.
`default_nettype none

module lzoc_sine #(
  parameter int unsigned SINE_TABLE_BITS = 10
) (
  input  wire logic        [15:0] angle_i,
  output      logic signed [15:0] sine_o
);
  import lzoc_pkg::*;

  localparam int unsigned QSteps = 1 << (SINE_TABLE_BITS - 2);
  localparam int unsigned IdxW   = SINE_TABLE_BITS - 1;

  logic [15:0]                  rom [QSteps+1];
  logic [SINE_TABLE_BITS-1:0]   phase;
  logic [1:0]                   quad;
  logic [SINE_TABLE_BITS-3:0]   step;
  logic [IdxW-1:0]              idx;
  logic [15:0]                  mag;

  // Build the constant table
  for (genvar k = 0; k <= QSteps; k++) begin : g_rom
    assign rom[k] = sine_entry(k, SINE_TABLE_BITS);
  end

  // Fold the phase into the first quadrant, mirror odd quadrants
  assign phase = angle_i[15 -: SINE_TABLE_BITS];
  assign quad  = phase[SINE_TABLE_BITS-1 -: 2];
  assign step  = phase[SINE_TABLE_BITS-3:0];
  assign idx   = quad[0] ? IdxW'(QSteps) - {1'b0, step} : {1'b0, step};
  assign mag   = rom[idx];

  // Negate the lower half-wave
  assign sine_o = quad[1] ? -$signed(mag) : $signed(mag);

endmodule

`default_nettype wire

// ===== rtl/core/lzoc_xform.sv =====
// Range gate and polar to robot-frame transform of one lidar return.
`default_nettype none

module lzoc_xform #(
  parameter int unsigned SINE_TABLE_BITS = 10
) (
  input  wire lzoc_pkg::in_t  item_i,
  input  wire logic [31:0]    range_window_i,
  input  wire logic [47:0]    mount_pose_i,
  output      lzoc_pkg::pt_t  pt_o
);
  import lzoc_pkg::*;

  logic        [15:0] ang;
  logic signed [15:0] sin_v;
  logic signed [15:0] cos_v;
  logic signed [32:0] prod_c;
  logic signed [32:0] prod_s;
  logic signed [33:0] rnd_c;
  logic signed [33:0] rnd_s;

  // Beam plus mount angle, wraps per turn
  assign ang = item_i.beam_angle + mount_pose_i[47:32];

  lzoc_sine #(.SINE_TABLE_BITS(SINE_TABLE_BITS)) u_sin (
    .angle_i (ang),
    .sine_o  (sin_v)
  );

  lzoc_sine #(.SINE_TABLE_BITS(SINE_TABLE_BITS)) u_cos (
    .angle_i (ang + QUARTER_TURN),
    .sine_o  (cos_v)
  );

  // Scale by range, round half up by 15 bits
  assign prod_c = $signed({1'b0, item_i.range_mm}) * cos_v;
  assign prod_s = $signed({1'b0, item_i.range_mm}) * sin_v;
  assign rnd_c  = 34'(prod_c) + 34'sd16384;
  assign rnd_s  = 34'(prod_s) + 34'sd16384;

  // Add mount offsets and gate on the exclusive range window
  always_comb begin
    pt_o.x = sext_mm(mount_pose_i[15:0])  + rnd_c[33:15];
    pt_o.y = sext_mm(mount_pose_i[31:16]) + rnd_s[33:15];
    pt_o.keep = (item_i.range_mm > range_window_i[15:0]) &&
                (item_i.range_mm < range_window_i[31:16]);
    pt_o.area_disable = item_i.area_disable;
    pt_o.last_point   = item_i.last_point;
  end

endmodule

`default_nettype wire

// ===== rtl/core/lzoc_zones.sv =====
// Rectangle tests, saturating hit counters and per-area level report.
`default_nettype none

module lzoc_zones #(
  parameter int unsigned AREAS      = 2,
  parameter int unsigned LEVELS     = 3,
  parameter int unsigned MIN_POINTS = 1
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          fire_i,
  input  wire lzoc_pkg::pt_t pt_i,
  input  wire logic [63:0]   rect_i [AREAS*LEVELS],
  output      lzoc_pkg::out_t result_o
);
  import lzoc_pkg::*;

  localparam int unsigned Zones = AREAS * LEVELS;

  logic [CNT_W-1:0] cnt_q   [Zones];
  logic [CNT_W-1:0] cnt_d   [Zones];
  logic [CNT_W-1:0] cnt_inc [Zones];
  logic [Zones-1:0] in_rect;
  logic [Zones-1:0] hit_first;
  logic [1:0]       codes   [AREAS];

  // Test the point against every rectangle, edges included
  always_comb begin
    for (int z = 0; z < Zones; z++) begin
      in_rect[z] = (pt_i.x >= sext_mm(rect_i[z][15:0]))  &&
                   (pt_i.y <= sext_mm(rect_i[z][31:16])) &&
                   (pt_i.x <= sext_mm(rect_i[z][47:32])) &&
                   (pt_i.y >= sext_mm(rect_i[z][63:48]));
    end
  end

  // Pick the first matching level per area and bump its counter; a last return clears them all
  always_comb begin : p_count
    logic found;
    for (int a = 0; a < AREAS; a++) begin
      found = 1'b0;
      for (int l = 0; l < LEVELS; l++) begin
        hit_first[a*LEVELS+l] = pt_i.keep && in_rect[a*LEVELS+l] && !found;
        found = found || in_rect[a*LEVELS+l];
      end
    end
    for (int z = 0; z < Zones; z++) begin
      cnt_inc[z] = (hit_first[z] && (cnt_q[z] != CNT_MAX)) ? cnt_q[z] + 1'b1 : cnt_q[z];
      if (fire_i) cnt_d[z] = pt_i.last_point ? '0 : cnt_inc[z];
      else        cnt_d[z] = cnt_q[z];
    end
  end

  // Report the first level with enough hits, after this point is counted
  always_comb begin : p_report
    logic done;
    logic [1:0] code;
    for (int a = 0; a < AREAS; a++) begin
      done = 1'b0;
      code = '0;
      for (int l = 0; l < LEVELS; l++) begin
        if (!done && (cnt_inc[a*LEVELS+l] >= CNT_W'(MIN_POINTS))) begin
          code = 2'(l + 1);
          done = 1'b1;
        end
      end
      if ((a < 2) && pt_i.area_disable[1'(a)]) code = '0;
      codes[a] = code;
    end
  end

  assign result_o.front_level = codes[0];
  if (AREAS > 1) begin : g_side
    assign result_o.side_level = codes[1];
  end else begin : g_no_side
    assign result_o.side_level = '0;
  end

  // Hold the hit counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int z = 0; z < Zones; z++) cnt_q[z] <= '0;
    end else begin
      for (int z = 0; z < Zones; z++) cnt_q[z] <= cnt_d[z];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/lidar_zone_obstacle_classifier.sv =====
// Top level of the lidar zone obstacle classifier: registers, pipeline and handshakes.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-------------------------------
//  in      | input     | in_valid_i/in_ready_o | in_data_i  (range, angle, flags)
//  out     | output    | out_valid_o/out_ready_i | out_data_o (front/side level)
//  cfg     | input     | cfg_we_i (no wait)    | cfg_idx_i, cfg_data_i
//
// One return is accepted per cycle while the pipe does not stall. Three register
// stages: input register, transformed point register (after the sine lookup and
// range multiply), and the result register loaded when a last_point return updates
// the counters. A result is valid once its return has reached the result register.
// Reset clears counters and loads the default window and mount pose.
// Only a last_point return waiting on a full result register stalls the pipe.
`default_nettype none

module lidar_zone_obstacle_classifier #(
  parameter int unsigned AREAS           = 2,
  parameter int unsigned LEVELS          = 3,
  parameter int unsigned MIN_POINTS      = 1,
  parameter int unsigned SINE_TABLE_BITS = 10
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output      logic                               in_ready_o,
  input  wire lzoc_pkg::in_t                      in_data_i,
  output      logic                               out_valid_o,
  input  wire logic                               out_ready_i,
  output      lzoc_pkg::out_t                     out_data_o,
  input  wire logic                               cfg_we_i,
  input  wire logic [lzoc_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [lzoc_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import lzoc_pkg::*;

  localparam int unsigned Zones     = AREAS * LEVELS;
  localparam int unsigned IdxWindow = Zones;
  localparam int unsigned IdxPose   = Zones + 1;

  logic [63:0] rect_q [Zones];
  logic [31:0] range_window_q;
  logic [47:0] mount_pose_q;

  logic  s1_valid_q;
  in_t   s1_q;
  logic  s2_valid_q;
  pt_t   s2_q;
  pt_t   s2_d;
  logic  out_valid_q;
  out_t  out_q;
  out_t  result;

  logic out_free;
  logic s2_fire;
  logic s2_en;
  logic s1_en;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int z = 0; z < Zones; z++) rect_q[z] <= '0;
      range_window_q <= RANGE_WINDOW_RST;
      mount_pose_q   <= MOUNT_POSE_RST;
    end else if (cfg_we_i) begin
      for (int z = 0; z < Zones; z++) begin
        if (cfg_idx_i == CFG_IDX_W'(z)) rect_q[z] <= cfg_data_i;
      end
      if (cfg_idx_i == CFG_IDX_W'(IdxWindow)) range_window_q <= cfg_data_i[31:0];
      if (cfg_idx_i == CFG_IDX_W'(IdxPose))   mount_pose_q   <= cfg_data_i[47:0];
    end
  end

  // Advance control: only a last return needs a free result register
  assign out_free   = !out_valid_q || out_ready_i;
  assign s2_fire    = s2_valid_q && (!s2_q.last_point || out_free);
  assign s2_en      = !s2_valid_q || s2_fire;
  assign s1_en      = !s1_valid_q || s2_en;
  assign in_ready_o = s1_en;

  lzoc_xform #(.SINE_TABLE_BITS(SINE_TABLE_BITS)) u_xform (
    .item_i         (s1_q),
    .range_window_i (range_window_q),
    .mount_pose_i   (mount_pose_q),
    .pt_o           (s2_d)
  );

  lzoc_zones #(
    .AREAS      (AREAS),
    .LEVELS     (LEVELS),
    .MIN_POINTS (MIN_POINTS)
  ) u_zones (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (s2_fire),
    .pt_i     (s2_q),
    .rect_i   (rect_q),
    .result_o (result)
  );

  // Pipeline valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_en) s1_valid_q <= in_valid_i;
      if (s2_en) s2_valid_q <= s1_valid_q;
      if (s2_fire && s2_q.last_point) out_valid_q <= 1'b1;
      else if (out_ready_i)           out_valid_q <= 1'b0;
    end
  end

  // Pipeline payload
  always_ff @(posedge clk_i) begin
    if (in_valid_i && s1_en) s1_q <= in_data_i;
    if (s1_valid_q && s2_en) s2_q <= s2_d;
    if (s2_fire && s2_q.last_point) out_q <= result;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // A new result only follows a last return leaving the point stage
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s2_fire && s2_q.last_point))
    else $error("result raised without a last return");

  // Input back-pressure only when both the input and point stages hold an item
  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> s1_valid_q && s2_valid_q)
    else $error("input stalled with room in the pipeline");

  // A stalled point stage keeps its item
  a_point_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q && !s2_fire |=> s2_valid_q && $stable(s2_q))
    else $error("point stage lost a stalled item");

endmodule

`default_nettype wire
